>>> sv/tftp_pkg.sv
// shared types, constants and helpers for the tftp data receiver
package tftp_pkg;

  // payload size of a full data block and the header length
  localparam int PAYLOAD_BYTES = 512;
  localparam int HDR_BYTES     = 4;
  localparam int BIDX_W        = $clog2(PAYLOAD_BYTES + HDR_BYTES + 1);
  localparam logic [BIDX_W-1:0] BIDX_HDR = BIDX_W'(HDR_BYTES);
  localparam logic [BIDX_W-1:0] BIDX_MAX = BIDX_W'(PAYLOAD_BYTES + HDR_BYTES);
  localparam logic [BIDX_W-1:0] BIDX_OP_HI  = BIDX_W'(0);
  localparam logic [BIDX_W-1:0] BIDX_OP_LO  = BIDX_W'(1);
  localparam logic [BIDX_W-1:0] BIDX_BLK_HI = BIDX_W'(2);
  localparam logic [BIDX_W-1:0] BIDX_BLK_LO = BIDX_W'(3);

  // tftp opcodes and characters
  localparam logic [15:0] OPC_DATA  = 16'd3;
  localparam logic [15:0] OPC_ERROR = 16'd5;
  localparam logic [7:0]  CH_CR     = 8'h0D;
  localparam logic [7:0]  CH_LF     = 8'h0A;

  // configuration port
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_NETASCII  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_RETRY_LIM = 3'd4;
  localparam logic [7:0] RETRY_LIM_RST = 8'd5;

  // results caused by one item
  localparam int MAX_RES = 4;
  localparam int RCNT_W  = $clog2(MAX_RES + 1);
  localparam int RIDX_W  = $clog2(MAX_RES);

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_COMPLETE = 3'd2,
    KIND_ABORT    = 3'd3,
    KIND_EXHAUST  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] slot;
    logic [RCNT_W-1:0]  cnt;
  } res_set_t;

  // append one result to a set
  function automatic res_set_t push_res(res_set_t s, kind_t kind, logic [15:0] value);
    res_set_t r;
    r = s;
    if (s.cnt < RCNT_W'(MAX_RES)) begin
      r.slot[s.cnt[RIDX_W-1:0]].kind  = kind;
      r.slot[s.cnt[RIDX_W-1:0]].value = value;
      r.slot[s.cnt[RIDX_W-1:0]].last  = 1'b0;
      r.cnt = s.cnt + RCNT_W'(1);
    end
    return r;
  endfunction

endpackage

>>> sv/tftp_rx_cfg.sv
// configuration registers behind the apb port
module tftp_rx_cfg import tftp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              netascii,
  output logic [7:0]        retry_lim
);

  logic       netascii_r;
  logic [7:0] retry_lim_r;
  logic       wr_en;

  assign wr_en = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      netascii_r  <= 1'b0;
      retry_lim_r <= RETRY_LIM_RST;
    end else if (wr_en) begin
      if (paddr == REG_NETASCII) begin
        netascii_r <= pwdata[0];
      end
      if (paddr == REG_RETRY_LIM) begin
        retry_lim_r <= pwdata[7:0];
      end
    end
  end

  // read mux
  always_comb begin
    prdata = 32'd0;
    if (paddr == REG_NETASCII) begin
      prdata = {31'd0, netascii_r};
    end else if (paddr == REG_RETRY_LIM) begin
      prdata = {24'd0, retry_lim_r};
    end
  end

  assign netascii  = netascii_r;
  assign retry_lim = retry_lim_r;

endmodule

>>> sv/tftp_rx_core.sv
// input register and per-item protocol logic of the tftp receiver
module tftp_rx_core import tftp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_byte,
  input  logic       in_eop,
  input  logic       netascii,
  input  logic [7:0] retry_lim,
  input  logic       buf_free,
  output logic       load,
  output res_set_t   res
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RX   = 2'd1,
    ST_DONE = 2'd2
  } xfer_t;

  // input register
  logic       item_vld_r;
  op_t        op_r;
  logic [7:0] byte_r;
  logic       eop_r;

  // transfer state
  xfer_t             st_r, st_nxt;
  logic [15:0]       exp_r, exp_nxt;
  logic [7:0]        retry_r, retry_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [15:0]       opc_r, opc_nxt;
  logic [15:0]       blk_r, blk_nxt;
  logic              crp_r, crp_nxt;
  res_set_t          rs;

  assign load     = item_vld_r & buf_free;
  assign in_ready = ~item_vld_r | buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r   <= op_t'(in_op);
      byte_r <= in_byte;
      eop_r  <= in_eop;
    end
  end

  // next state and results for the registered item
  always_comb begin
    logic skip;
    st_nxt    = st_r;
    exp_nxt   = exp_r;
    retry_nxt = retry_r;
    bidx_nxt  = bidx_r;
    opc_nxt   = opc_r;
    blk_nxt   = blk_r;
    crp_nxt   = crp_r;
    rs        = '0;
    skip      = 1'b0;
    unique case (op_r)
      OP_START: begin
        st_nxt    = ST_RX;
        exp_nxt   = 16'd1;
        retry_nxt = 8'd0;
        bidx_nxt  = '0;
        opc_nxt   = 16'd0;
        blk_nxt   = 16'd0;
        crp_nxt   = 1'b0;
      end
      OP_TICK: begin
        if (st_r == ST_RX) begin
          if (retry_r != 8'hFF) begin
            retry_nxt = retry_r + 8'd1;
          end
          if (retry_nxt >= retry_lim) begin
            rs     = push_res(rs, KIND_EXHAUST, 16'd0);
            st_nxt = ST_DONE;
          end
        end
      end
      OP_BYTE: begin
        if (st_r == ST_RX) begin
          // header capture or payload byte
          if (bidx_r < BIDX_MAX) begin
            if (bidx_r == BIDX_OP_HI) begin
              opc_nxt = {byte_r, 8'd0};
            end else if (bidx_r == BIDX_OP_LO) begin
              opc_nxt = {opc_r[15:8], byte_r};
            end else if (bidx_r == BIDX_BLK_HI) begin
              blk_nxt = {byte_r, 8'd0};
            end else if (bidx_r == BIDX_BLK_LO) begin
              blk_nxt = {blk_r[15:8], byte_r};
            end else if (opc_r == OPC_DATA && blk_r == exp_r) begin
              // netascii cr lf folding
              if (crp_r) begin
                crp_nxt = 1'b0;
                if (netascii && byte_r == CH_LF) begin
                  rs   = push_res(rs, KIND_BYTE, {8'd0, CH_LF});
                  skip = 1'b1;
                end else begin
                  rs = push_res(rs, KIND_BYTE, {8'd0, CH_CR});
                end
              end
              if (!skip) begin
                if (netascii && byte_r == CH_CR) begin
                  crp_nxt = 1'b1;
                end else begin
                  rs = push_res(rs, KIND_BYTE, {8'd0, byte_r});
                end
              end
            end
            bidx_nxt = bidx_r + BIDX_W'(1);
          end
          // packet end
          if (eop_r) begin
            if (bidx_nxt >= BIDX_HDR) begin
              retry_nxt = 8'd0;
              if (opc_nxt == OPC_ERROR) begin
                rs     = push_res(rs, KIND_ABORT, 16'd0);
                st_nxt = ST_DONE;
              end else if (opc_nxt == OPC_DATA) begin
                if (blk_nxt == exp_r) begin
                  if (crp_nxt) begin
                    rs = push_res(rs, KIND_BYTE, {8'd0, CH_CR});
                  end
                  rs      = push_res(rs, KIND_ACK, blk_nxt);
                  exp_nxt = exp_r + 16'd1;
                  if (bidx_nxt < BIDX_MAX) begin
                    rs     = push_res(rs, KIND_COMPLETE, 16'd0);
                    st_nxt = ST_DONE;
                  end
                end else if (blk_nxt < exp_r) begin
                  rs = push_res(rs, KIND_ACK, blk_nxt);
                end
              end
            end
            crp_nxt  = 1'b0;
            bidx_nxt = '0;
          end
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
    // mark the final result of the item
    if (rs.cnt != '0) begin
      rs.slot[RIDX_W'(rs.cnt - RCNT_W'(1))].last = 1'b1;
    end
  end

  assign res = rs;

  // state update once the item's results have a place
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      exp_r   <= 16'd1;
      retry_r <= 8'd0;
      bidx_r  <= '0;
      opc_r   <= 16'd0;
      blk_r   <= 16'd0;
      crp_r   <= 1'b0;
    end else if (load) begin
      st_r    <= st_nxt;
      exp_r   <= exp_nxt;
      retry_r <= retry_nxt;
      bidx_r  <= bidx_nxt;
      opc_r   <= opc_nxt;
      blk_r   <= blk_nxt;
      crp_r   <= crp_nxt;
    end
  end

endmodule

>>> sv/tftp_rx_outbuf.sv
// result register set, drained one result per handshake
module tftp_rx_outbuf import tftp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  res_set_t res,
  output logic     buf_free,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     out_res
);

  res_t              slot_r [MAX_RES];
  logic [RCNT_W-1:0] cnt_r;
  logic [RIDX_W-1:0] rd_r;
  logic              take;
  logic              at_last;

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid & out_ready;
  assign at_last   = (RCNT_W'(rd_r) + RCNT_W'(1)) == cnt_r;
  assign buf_free  = ~out_valid | (take & at_last);
  assign out_res   = slot_r[rd_r];

  // fill and drain control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (load) begin
      cnt_r <= res.cnt;
      rd_r  <= '0;
    end else if (take) begin
      if (at_last) begin
        cnt_r <= '0;
        rd_r  <= '0;
      end else begin
        rd_r <= rd_r + RIDX_W'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        slot_r[i] <= res.slot[i];
      end
    end
  end

endmodule

>>> sv/tftp_data_receiver_top.sv
// tftp data receiver: one datagram byte, tick or start per input item
// results of an item pass from the input register into the result register set and on to out_*
// throughput: one item per cycle while each item gives at most one result and out_tready
//   is high; an item that gives more results holds the output register set until all are taken
// items that give no result pass at one per cycle while the output register set is free
// reset: synchronous active-low rst_n clears handshakes and transfer state to idle
module tftp_data_receiver_top import tftp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic [1:0]        in_tuser,   // [1:0] operation
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [15:0] value
  output logic [2:0]        out_tuser,  // [2:0] kind
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic       netascii;
  logic [7:0] retry_lim;
  logic       buf_free;
  logic       load;
  res_set_t   res;
  res_t       out_res;

  assign cfg_pready = 1'b1;

  // configuration registers
  tftp_rx_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .netascii   (netascii),
    .retry_lim  (retry_lim)
  );

  // protocol logic
  tftp_rx_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_byte    (in_tdata),
    .in_eop     (in_tlast),
    .netascii   (netascii),
    .retry_lim  (retry_lim),
    .buf_free   (buf_free),
    .load       (load),
    .res        (res)
  );

  // result registers
  tftp_rx_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .res      (res),
    .buf_free (buf_free),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = out_res.value;
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

>>> sv/tftp_rx_chk.sv
// port-level checks for the tftp data receiver
module tftp_rx_chk import tftp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // nothing is offered right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // only file bytes and acks carry a value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_BYTE && out_tuser != KIND_ACK |-> out_tdata == 16'd0)
    else $error("nonzero value on status result");

  // file bytes fit in eight bits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_BYTE |-> out_tdata[15:8] == 8'd0)
    else $error("file byte wider than eight bits");

  // a terminating result always closes its run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_COMPLETE || out_tuser == KIND_ABORT
      || out_tuser == KIND_EXHAUST) |-> out_tlast)
    else $error("terminal result not last of run");

endmodule

bind tftp_data_receiver_top tftp_rx_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

>>> tb/tftp_data_receiver_top_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the tftp data receiver with stream stimulus and result scoreboard
module tftp_data_receiver_top_test;
  import tftp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 260;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [15:0] OPC_ACK = 16'd4;

  typedef enum logic [1:0] {
    XFER_IDLE = 2'd0,
    XFER_RX   = 2'd1,
    XFER_DONE = 2'd2
  } xfer_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       eop;
  } rx_item_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic [1:0]        in_tuser;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;
  logic [2:0]        out_tuser;
  logic              out_tlast;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  tftp_data_receiver_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // stimulus and scoreboard storage
  rx_item_t pending_items [$];
  res_t     expected_results [$];
  res_t     step_results [$];

  // receiver mirror: transfer state and configuration
  xfer_t             xfer_state  = XFER_IDLE;
  logic [15:0]       next_block  = 16'd1;
  logic [7:0]        timeout_run = 8'd0;
  logic [BIDX_W-1:0] pkt_len     = '0;
  logic [15:0]       opcode_hdr  = 16'd0;
  logic [15:0]       block_hdr   = 16'd0;
  bit                cr_held     = 1'b0;
  bit                ascii_on    = 1'b0;
  logic [7:0]        retry_limit = RETRY_LIM_RST;

  // run control and bookkeeping
  bit in_fire     = 1'b0;
  bit tail_quiet  = 1'b0;
  bit tick_noise  = 1'b0;
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  int in_gap      = 0;
  int out_gap     = 0;
  int items_queued = 0;
  int items_in    = 0;
  int results_out = 0;
  int fail_count  = 0;
  int cycle_count = 0;
  int kind_seen [5];

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // append one result for the item being predicted, at most MAX_RES per item
  function automatic void add_result(kind_t k, logic [15:0] v);
    res_t r;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    if (step_results.size() < MAX_RES) step_results.push_back(r);
  endfunction

  // work out the results of one accepted item and queue them as expected
  function automatic void predict_receiver(rx_item_t it);
    res_t r;
    bit   lf_taken;
    lf_taken = 1'b0;
    step_results.delete();
    if (it.op == OP_START) begin
      next_block  = 16'd1;
      timeout_run = 8'd0;
      pkt_len     = '0;
      opcode_hdr  = 16'd0;
      block_hdr   = 16'd0;
      cr_held     = 1'b0;
      xfer_state  = XFER_RX;
    end else if (xfer_state == XFER_RX) begin
      if (it.op == OP_TICK) begin
        if (timeout_run != 8'hFF) timeout_run++;
        if (timeout_run >= retry_limit) begin
          add_result(KIND_EXHAUST, 16'd0);
          xfer_state = XFER_DONE;
        end
      end else if (it.op == OP_BYTE) begin
        // header capture, then payload of the expected data block
        if (pkt_len < BIDX_MAX) begin
          case (pkt_len)
            BIDX_OP_HI:  opcode_hdr = {it.data, 8'h00};
            BIDX_OP_LO:  opcode_hdr[7:0] = it.data;
            BIDX_BLK_HI: block_hdr = {it.data, 8'h00};
            BIDX_BLK_LO: block_hdr[7:0] = it.data;
            default: begin
              if (opcode_hdr == OPC_DATA && block_hdr == next_block) begin
                if (cr_held) begin
                  cr_held = 1'b0;
                  if (ascii_on && it.data == CH_LF) begin
                    add_result(KIND_BYTE, {8'h00, CH_LF});
                    lf_taken = 1'b1;
                  end else begin
                    add_result(KIND_BYTE, {8'h00, CH_CR});
                  end
                end
                if (!lf_taken) begin
                  if (ascii_on && it.data == CH_CR) cr_held = 1'b1;
                  else add_result(KIND_BYTE, {8'h00, it.data});
                end
              end
            end
          endcase
          pkt_len++;
        end
        // end of datagram: ack, completion, abort
        if (it.eop) begin
          if (pkt_len >= BIDX_HDR) begin
            timeout_run = 8'd0;
            if (opcode_hdr == OPC_ERROR) begin
              add_result(KIND_ABORT, 16'd0);
              xfer_state = XFER_DONE;
            end else if (opcode_hdr == OPC_DATA) begin
              if (block_hdr == next_block) begin
                if (cr_held) add_result(KIND_BYTE, {8'h00, CH_CR});
                add_result(KIND_ACK, block_hdr);
                next_block++;
                if (int'(pkt_len - BIDX_HDR) < PAYLOAD_BYTES) begin
                  add_result(KIND_COMPLETE, 16'd0);
                  xfer_state = XFER_DONE;
                end
              end else if (block_hdr < next_block) begin
                add_result(KIND_ACK, block_hdr);
              end
            end
          end
          cr_held = 1'b0;
          pkt_len = '0;
        end
      end
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // input side: present queued items with random idle bursts
  always @(negedge clk) begin : in_drive
    rx_item_t nxt;
    bit       v;
    if (rst_n === 1'b1) begin
      if ($urandom_range(0, 63) == 0) in_idle_on = !in_idle_on;
      if (!(in_tvalid && !in_fire)) begin
        v = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (!tail_quiet && in_idle_on && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 7);
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          v = 1'b1;
          {in_tuser, in_tdata, in_tlast} <= {nxt.op, nxt.data, nxt.eop};
        end
        in_tvalid <= v;
      end
    end
  end

  // result side: random stall bursts
  always @(negedge clk) begin : out_drive
    if (rst_n !== 1'b1) begin
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) out_idle_on = !out_idle_on;
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!tail_quiet && out_idle_on && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // sample handshakes: check results, predict accepted items, track register writes
  always @(posedge clk) begin : observe
    res_t     want;
    rx_item_t got;
    in_fire = (rst_n === 1'b1) && in_tvalid && in_tready;
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      results_out++;
      if (out_tuser <= KIND_EXHAUST) kind_seen[out_tuser]++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d value %0h last_of_run %0b",
               out_tuser, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          fail_count++;
        end
        if (out_tdata !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
    if (in_fire) begin
      got.op   = in_tuser;
      got.data = in_tdata;
      got.eop  = in_tlast;
      items_in++;
      predict_receiver(got);
    end
    if (rst_n === 1'b1 && cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr)
        REG_NETASCII:  ascii_on = cfg_pwdata[0];
        REG_RETRY_LIM: retry_limit = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  task automatic queue_item(logic [1:0] op, logic [7:0] data, logic eop);
    rx_item_t it;
    it.op   = op;
    it.data = data;
    it.eop  = eop;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // four header bytes, big-endian opcode then block number
  task automatic queue_header(logic [15:0] opc, logic [15:0] blk, bit hdr_only);
    queue_item(OP_BYTE, opc[15:8], 1'b0);
    queue_item(OP_BYTE, opc[7:0], 1'b0);
    queue_item(OP_BYTE, blk[15:8], 1'b0);
    queue_item(OP_BYTE, blk[7:0], hdr_only);
  endtask

  // payload bytes, text-like when crlf is set, last one ends the datagram
  task automatic queue_body(int plen, bit crlf);
    logic [7:0] b;
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      if (crlf) begin
        case ($urandom_range(0, 3))
          0: b = CH_CR;
          1: b = CH_LF;
          default: ;
        endcase
      end
      if (tick_noise && $urandom_range(0, 199) == 0)
        queue_item(OP_TICK, 8'($urandom), 1'($urandom));
      queue_item(OP_BYTE, b, i == plen - 1);
    end
  endtask

  task automatic queue_packet(logic [15:0] opc, logic [15:0] blk, int plen, bit crlf);
    queue_header(opc, blk, plen == 0);
    queue_body(plen, crlf);
  endtask

  // one transfer: mostly in-order blocks, with duplicates, strays, ticks and noise
  task automatic run_transfer();
    logic [15:0] blk;
    logic [15:0] opc;
    bit          live;
    int          plen;
    int          ticks;
    int          n;
    blk   = 16'd1;
    live  = 1'b1;
    ticks = 0;
    queue_item(OP_START, 8'($urandom), 1'($urandom));
    while (live) begin
      plen = ($urandom_range(0, 15) == 0) ?
             $urandom_range(PAYLOAD_BYTES, PAYLOAD_BYTES + 12) : $urandom_range(0, 10);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          queue_packet(OPC_DATA, blk, plen, 1'($urandom));
          ticks = 0;
          if (plen >= PAYLOAD_BYTES) blk++;
          else live = 1'b0;
        end
        9, 10: begin
          queue_packet(OPC_DATA, 16'($urandom_range(0, blk - 1)), $urandom_range(0, 6),
                       1'($urandom));
          ticks = 0;
        end
        11: begin
          queue_packet(OPC_DATA, ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                       blk + 16'($urandom_range(1, 4)), $urandom_range(0, 6), 1'b0);
          ticks = 0;
        end
        12: begin
          opc = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom);
          if (opc == OPC_DATA || opc == OPC_ERROR) opc = OPC_ACK;
          queue_packet(opc, 16'($urandom), $urandom_range(0, 6), 1'b0);
          ticks = 0;
        end
        13: begin
          if ($urandom_range(0, 2) == 0) begin
            queue_packet(OPC_ERROR, 16'($urandom), $urandom_range(0, 6), 1'b0);
            live = 1'b0;
          end
        end
        14: begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) queue_item(OP_BYTE, 8'($urandom), i == n - 1);
        end
        15, 16: begin
          n = $urandom_range(1, 3);
          repeat (n) queue_item(OP_TICK, 8'($urandom), 1'($urandom));
          ticks += n;
          if (ticks >= retry_limit) live = 1'b0;
        end
        default: queue_item(OP_UNUSED, 8'($urandom), 1'($urandom));
      endcase
    end
    // sender repeating its final block after the transfer is over
    if ($urandom_range(0, 2) == 0) queue_packet(OPC_DATA, blk, $urandom_range(0, 4), 1'b0);
  endtask

  // wait until every item is taken and every result seen, then let the pipe settle
  task automatic wait_idle();
    @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write in setup and access cycles, then read back
  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== value) begin
      $error("register %0h: expected %0h, got %0h", addr, value, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    int rand_start;
    int n;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = OP_BYTE;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = REG_NETASCII;
    cfg_pwdata  = 32'd0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: binary mode, five retries
    queue_item(OP_BYTE, 8'hFF, 1'b1);
    queue_item(OP_TICK, 8'h00, 1'b0);
    queue_item(OP_UNUSED, 8'hA5, 1'b1);
    queue_item(OP_START, 8'h00, 1'b1);
    // short datagram is dropped
    queue_item(OP_BYTE, 8'h00, 1'b0);
    queue_item(OP_BYTE, OPC_DATA[7:0], 1'b0);
    queue_item(OP_BYTE, 8'h00, 1'b1);
    queue_item(OP_TICK, 8'h00, 1'b0);
    queue_item(OP_TICK, 8'hFF, 1'b1);
    queue_packet(OPC_DATA, 16'd1, PAYLOAD_BYTES, 1'b1);
    // duplicates acked, later block and other opcodes dropped
    queue_packet(OPC_DATA, 16'd0, 2, 1'b0);
    queue_packet(OPC_DATA, 16'd1, 1, 1'b0);
    queue_packet(OPC_DATA, 16'hFFFF, 1, 1'b0);
    queue_packet(OPC_ACK, 16'd2, 0, 1'b0);
    queue_packet({8'hFF, OPC_DATA[7:0]}, 16'd2, 1, 1'b0);
    // oversize block counts as full, then a short block with a tick inside ends it
    queue_packet(OPC_DATA, 16'd2, PAYLOAD_BYTES + 8, 1'b0);
    queue_header(OPC_DATA, 16'd3, 1'b0);
    queue_item(OP_BYTE, 8'h00, 1'b0);
    queue_item(OP_TICK, 8'h00, 1'b1);
    queue_item(OP_BYTE, 8'hFF, 1'b0);
    queue_item(OP_BYTE, CH_CR, 1'b1);
    queue_packet(OPC_DATA, 16'd3, 2, 1'b0);
    queue_item(OP_TICK, 8'h00, 1'b0);
    // peer error and retry exhaustion
    queue_item(OP_START, 8'hFF, 1'b0);
    queue_packet(OPC_ERROR, 16'd0, 3, 1'b0);
    queue_item(OP_START, 8'h00, 1'b0);
    repeat (5) queue_item(OP_TICK, 8'h00, 1'b0);
    wait_idle();

    // netascii with a single retry
    cfg_write(REG_NETASCII, 32'd1);
    cfg_write(REG_RETRY_LIM, 32'd1);
    queue_item(OP_START, 8'h00, 1'b0);
    queue_header(OPC_DATA, 16'd1, 1'b0);
    queue_body(PAYLOAD_BYTES - 1, 1'b1);
    queue_item(OP_BYTE, CH_CR, 1'b1);
    // lf at the start of the next block is not joined with the trailing cr
    queue_header(OPC_DATA, 16'd2, 1'b0);
    queue_item(OP_BYTE, CH_LF, 1'b0);
    queue_item(OP_BYTE, 8'h61, 1'b0);
    queue_item(OP_BYTE, CH_CR, 1'b0);
    queue_item(OP_BYTE, CH_LF, 1'b0);
    queue_item(OP_BYTE, CH_CR, 1'b0);
    queue_item(OP_BYTE, CH_CR, 1'b0);
    queue_item(OP_BYTE, CH_LF, 1'b0);
    queue_item(OP_BYTE, CH_CR, 1'b0);
    queue_item(OP_BYTE, 8'h62, 1'b0);
    queue_item(OP_BYTE, CH_CR, 1'b1);
    queue_item(OP_START, 8'h00, 1'b0);
    queue_packet(OPC_DATA, 16'd1, 0, 1'b0);
    queue_item(OP_START, 8'h00, 1'b0);
    queue_item(OP_TICK, 8'h00, 1'b0);
    // cr held across a switch back to binary mode
    queue_item(OP_START, 8'h00, 1'b0);
    queue_header(OPC_DATA, 16'd1, 1'b0);
    queue_item(OP_BYTE, 8'h78, 1'b0);
    queue_item(OP_BYTE, CH_CR, 1'b0);
    wait_idle();
    cfg_write(REG_NETASCII, 32'd0);
    queue_item(OP_BYTE, CH_LF, 1'b1);
    wait_idle();
    // zero retries fail on the first tick
    cfg_write(REG_RETRY_LIM, 32'd0);
    queue_item(OP_START, 8'h00, 1'b0);
    queue_item(OP_TICK, 8'h00, 1'b0);
    wait_idle();

    // random transfers under changing settings
    rand_start = items_queued;
    while (items_queued - rand_start < RANDOM_ITEMS) begin
      wait_idle();
      cfg_write(REG_NETASCII, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 4))
        0: n = 1;
        1: n = 2;
        2: n = 3;
        3: n = 255;
        default: n = $urandom_range(1, 255);
      endcase
      cfg_write(REG_RETRY_LIM, 32'(n));
      tick_noise = (n >= 3);
      repeat ($urandom_range(2, 4)) run_transfer();
    end

    // closing stretch at full rate on both sides
    wait_idle();
    tail_quiet = 1'b1;
    run_transfer();
    run_transfer();
    wait_idle();
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end

    $display("Run covered %0d input items and %0d results in %0d cycles",
             items_in, results_out, cycle_count);
    $display("  file bytes %0d, acks %0d, completions %0d, aborts %0d, retry failures %0d",
             kind_seen[KIND_BYTE], kind_seen[KIND_ACK], kind_seen[KIND_COMPLETE],
             kind_seen[KIND_ABORT], kind_seen[KIND_EXHAUST]);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
